// ===== rtl/kf2_pkg.sv =====
// ----------------------------------------------------------------------------
// kf2_pkg
// shared types and constants for the two-state kalman filter
// ----------------------------------------------------------------------------
package kf2_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int CfgW     = 32;
  localparam int IdxW     = 3;

  localparam logic [IdxW-1:0] RegTimeStep = 3'd0;
  localparam logic [IdxW-1:0] RegMeasVar  = 3'd1;
  localparam logic [IdxW-1:0] RegProcPos  = 3'd2;
  localparam logic [IdxW-1:0] RegProcVel  = 3'd3;
  localparam logic [IdxW-1:0] RegCtrlPos  = 3'd4;
  localparam logic [IdxW-1:0] RegCtrlVel  = 3'd5;
  localparam logic [IdxW-1:0] RegInitCov  = 3'd6;

  // 1000.0 at FracBits, saturated to the 31 bit register range
  localparam longint InitCovFull = longint'(1000) <<< FracBits;
  localparam logic [30:0] InitCovReset = (InitCovFull > 64'sh7FFFFFFF) ?
      31'h7FFFFFFF : InitCovFull[30:0];

  // divider: quotient bits needed for |num*2^F / den| before saturation
  localparam int DivBits = DataW + FracBits;
  localparam int DivCntW = $clog2(DivBits + 1);

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S,
    ST_DIV1,
    ST_DIV1W,
    ST_DIV2,
    ST_DIV2W,
    ST_U_POS,
    ST_U_VEL,
    ST_U_A,
    ST_U_B,
    ST_U_C,
    ST_P_POS,
    ST_P_POS2,
    ST_P_VEL,
    ST_P_NB,
    ST_P_A1,
    ST_P_A2,
    ST_P_A3,
    ST_P_C,
    ST_OUT
  } state_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+1:0] v);
    if (v > $signed({{2{1'b0}}, 1'b0, {(DataW-1){1'b1}}}))
      return {1'b0, {(DataW-1){1'b1}}};
    else if (v < $signed({{2{1'b1}}, 1'b1, {(DataW-1){1'b0}}}))
      return {1'b1, {(DataW-1){1'b0}}};
    else
      return v[DataW-1:0];
  endfunction

  // arithmetic shift floors, matching rounding toward minus infinity
  function automatic logic signed [DataW-1:0] sat_prod(input logic signed [2*DataW-1:0] p);
    logic signed [2*DataW-1:0] s;
    s = p >>> FracBits;
    if (s > $signed({{(DataW+1){1'b0}}, {(DataW-1){1'b1}}}))
      return {1'b0, {(DataW-1){1'b1}}};
    else if (s < $signed({{(DataW+1){1'b1}}, {(DataW-1){1'b0}}}))
      return {1'b1, {(DataW-1){1'b0}}};
    else
      return s[DataW-1:0];
  endfunction

endpackage

// ===== rtl/kf2_div.sv =====
// ----------------------------------------------------------------------------
// kf2_div
// restoring divider, one quotient bit per cycle, saturated gain result
// ----------------------------------------------------------------------------
module kf2_div import kf2_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  div_ctrl_t               ctrl,
  input  logic signed [DataW-1:0] num,
  input  logic signed [DataW-1:0] den,
  output div_stat_t               stat,
  output logic signed [DataW-1:0] quo
);

  div_state_t               state, state_next;
  logic [DivCntW-1:0]       cnt;
  logic [DivBits-1:0]       dividend;
  logic [DataW:0]           rem;
  logic [DivBits-1:0]       q;
  logic [DataW-1:0]         dmag;
  logic                     neg;
  logic [DataW:0]           trial;
  logic [DataW:0]           shifted;
  logic signed [DivBits+1:0] sq;

  assign shifted = {rem[DataW-1:0], dividend[DivBits-1]};
  assign trial   = shifted - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ctrl.start) cnt <= DivCntW'(DivBits);
      else if (state == DIV_RUN) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dividend <= {(num[DataW-1] ? -num : num), {FracBits{1'b0}}};
      dmag     <= den[DataW-1] ? -den : den;
      neg      <= num[DataW-1] ^ den[DataW-1];
      rem      <= '0;
      q        <= '0;
    end else if (state == DIV_RUN) begin
      dividend <= dividend << 1;
      if (!trial[DataW]) begin
        rem <= trial;
        q   <= {q[DivBits-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[DivBits-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (ctrl.start) state_next = DIV_RUN;
      DIV_RUN:  if (cnt == DivCntW'(1)) state_next = DIV_DONE;
      DIV_DONE: state_next = ctrl.start ? DIV_RUN : DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    sq  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    quo = (sq > $signed({{(DivBits-DataW+3){1'b0}}, {(DataW-1){1'b1}}})) ?
          {1'b0, {(DataW-1){1'b1}}} :
          (sq < $signed({{(DivBits-DataW+3){1'b1}}, {(DataW-1){1'b0}}})) ?
          {1'b1, {(DataW-1){1'b0}}} : sq[DataW-1:0];
  end

  assign stat.busy = (state == DIV_RUN);
  assign stat.done = (state == DIV_DONE);

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(state) == DIV_RUN) else $error("div done without run");
  a_cnt_zero_done: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> cnt == '0) else $error("div count not exhausted");
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    !(stat.busy && stat.done)) else $error("div busy and done");

endmodule

// ===== rtl/kalman_filter_2state_1meas.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_2state_1meas
// two-state constant-velocity kalman filter, one position measurement per item
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one measurement item (tdata = meas_pos, q16.16 signed).
//   m_axis returns one item per measurement: the predicted estimate, the
//   covariance after prediction and the singular flag in tuser.
//   cfg_we/cfg_idx/cfg_data write the seven registers while the block idles;
//   writing init_cov reloads the covariance to a diagonal and keeps the estimate.
// sequence:
//   after a measurement is accepted, the block forms s, then runs the shared
//   bit-serial divider twice for the two gains (48 quotient bits each), starting
//   the second pass once the first is done, then steps the shared 32x32 multiplier
//   and adder through the five update and eight prediction steps. when s is zero
//   the divider and the update are skipped. s_axis_tready is low while an item is
//   in work, so a new measurement is not taken before the last result has gone.
// reset:
//   rst (synchronous) loads registers to their defaults, clears the estimate
//   and sets the covariance to diag(init_cov).
// stall:
//   the result sits in the output register until m_axis_tready; the next
//   measurement is only taken after the result has been delivered.
// ----------------------------------------------------------------------------
module kalman_filter_2state_1meas import kf2_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DataW-1:0]  s_axis_tdata,   // meas_pos
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [5*DataW-1:0] m_axis_tdata,  // est_pos, est_vel, cov_pp, cov_pv, cov_vv
  output logic              m_axis_tuser,   // singular
  input  logic              cfg_we,
  input  logic [IdxW-1:0]   cfg_idx,
  input  logic [CfgW-1:0]   cfg_data
);

  // configuration registers
  logic [30:0] time_step, meas_variance, proc_var_pos, proc_var_vel, init_cov;
  logic signed [DataW-1:0] ctrl_pos, ctrl_vel;

  // filter state
  logic signed [DataW-1:0] state_pos, state_vel, cov_a, cov_b, cov_c;
  // work registers
  logic signed [DataW-1:0] z, s, k1, k2, ob, nb, acc, prod;
  logic                    singular;

  state_t state, state_next;

  // shared arithmetic: one multiplier with registered product, one adder
  logic signed [DataW-1:0] mul_a, mul_b, add_a, add_b;
  logic                    add_sub;
  logic signed [DataW+1:0] add_raw;
  logic signed [DataW-1:0] add_res;
  logic signed [DataW-1:0] dt;

  div_ctrl_t               dctrl;
  div_stat_t               dstat;
  logic signed [DataW-1:0] dnum, dquo;

  assign dt = $signed({1'b0, time_step});

  kf2_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dctrl),
    .num  (dnum),
    .den  (s),
    .stat (dstat),
    .quo  (dquo)
  );

  assign add_raw = add_sub ? ({{2{add_a[DataW-1]}}, add_a} - {{2{add_b[DataW-1]}}, add_b})
                           : ({{2{add_a[DataW-1]}}, add_a} + {{2{add_b[DataW-1]}}, add_b});
  assign add_res = sat32(add_raw);

  // each step: prod holds the product chosen last cycle; the adder folds it in
  always_comb begin
    mul_a = k1; mul_b = '0;
    add_a = acc; add_b = prod; add_sub = 1'b0;
    dctrl.start = 1'b0;
    dnum = cov_a;
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_S;
      ST_S: begin
        add_a = cov_a; add_b = $signed({1'b0, meas_variance});
        state_next = ST_DIV1;
      end
      ST_DIV1: begin
        if (s == '0) begin
          state_next = ST_P_POS;
          mul_a = dt; mul_b = state_vel;
        end else begin
          dctrl.start = 1'b1; dnum = cov_a;
          state_next = ST_DIV1W;
        end
      end
      ST_DIV1W: if (dstat.done) state_next = ST_DIV2;
      ST_DIV2: begin
        dctrl.start = 1'b1; dnum = cov_b;
        state_next = ST_DIV2W;
      end
      ST_DIV2W: if (dstat.done) begin
        state_next = ST_U_POS;
        mul_a = k1; mul_b = acc; // acc holds y
      end
      ST_U_POS: begin
        add_a = state_pos; add_b = prod;
        mul_a = dquo; mul_b = acc;
        state_next = ST_U_VEL;
      end
      ST_U_VEL: begin
        add_a = state_vel; add_b = prod;
        mul_a = k1; mul_b = cov_a;
        state_next = ST_U_A;
      end
      ST_U_A: begin
        // cov_b still holds the old value here; ob takes it at this edge
        add_a = cov_a; add_b = prod; add_sub = 1'b1;
        mul_a = k1; mul_b = cov_b;
        state_next = ST_U_B;
      end
      ST_U_B: begin
        add_a = ob; add_b = prod; add_sub = 1'b1;
        mul_a = k2; mul_b = ob;
        state_next = ST_U_C;
      end
      ST_U_C: begin
        add_a = cov_c; add_b = prod; add_sub = 1'b1;
        state_next = ST_P_POS;
      end
      ST_P_POS: begin
        mul_a = dt; mul_b = state_vel;
        state_next = ST_P_POS2;
      end
      ST_P_POS2: begin
        add_a = state_pos; add_b = prod;
        mul_a = dt; mul_b = cov_c;
        state_next = ST_P_VEL;
      end
      ST_P_VEL: begin
        add_a = acc; add_b = ctrl_pos;
        mul_a = dt; mul_b = cov_c;
        state_next = ST_P_NB;
      end
      ST_P_NB: begin
        add_a = cov_b; add_b = prod;
        mul_a = dt; mul_b = cov_b;
        state_next = ST_P_A1;
      end
      ST_P_A1: begin
        add_a = cov_a; add_b = prod;
        mul_a = dt; mul_b = nb;
        state_next = ST_P_A2;
      end
      ST_P_A2: begin
        add_a = acc; add_b = prod;
        state_next = ST_P_A3;
      end
      ST_P_A3: begin
        add_a = acc; add_b = $signed({1'b0, proc_var_pos});
        state_next = ST_P_C;
      end
      ST_P_C: begin
        add_a = cov_c; add_b = $signed({1'b0, proc_var_vel});
        state_next = ST_OUT;
      end
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    prod <= sat_prod(mul_a * mul_b);
    if (rst) begin
      time_step     <= 31'(longint'(1) <<< FracBits);
      meas_variance <= 31'(longint'(1) <<< FracBits);
      proc_var_pos  <= '0;
      proc_var_vel  <= '0;
      ctrl_pos      <= '0;
      ctrl_vel      <= '0;
      init_cov      <= InitCovReset;
      state_pos     <= '0;
      state_vel     <= '0;
      cov_a         <= $signed({1'b0, InitCovReset});
      cov_b         <= '0;
      cov_c         <= $signed({1'b0, InitCovReset});
      singular      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          RegTimeStep: time_step     <= cfg_data[30:0];
          RegMeasVar:  meas_variance <= cfg_data[30:0];
          RegProcPos:  proc_var_pos  <= cfg_data[30:0];
          RegProcVel:  proc_var_vel  <= cfg_data[30:0];
          RegCtrlPos:  ctrl_pos      <= cfg_data;
          RegCtrlVel:  ctrl_vel      <= cfg_data;
          RegInitCov: begin
            init_cov <= cfg_data[30:0];
            cov_a    <= $signed({1'b0, cfg_data[30:0]});
            cov_b    <= '0;
            cov_c    <= $signed({1'b0, cfg_data[30:0]});
          end
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) z <= s_axis_tdata;
        ST_S: s <= add_res;
        ST_DIV1: begin
          singular <= (s == '0);
          // y = z - pos
          acc <= sat32({{2{z[DataW-1]}}, z} - {{2{state_pos[DataW-1]}}, state_pos});
        end
        ST_DIV1W: if (dstat.done) k1 <= dquo;
        ST_DIV2W: if (dstat.done) k2 <= dquo;
        ST_U_POS: state_pos <= add_res;
        ST_U_VEL: state_vel <= add_res;
        ST_U_A: begin
          cov_a <= add_res;
          ob    <= cov_b;
        end
        ST_U_B: cov_b <= add_res;
        ST_U_C: cov_c <= add_res;
        ST_P_POS2: acc <= add_res;
        ST_P_VEL: begin
          state_pos <= add_res;
          state_vel <= sat32({{2{state_vel[DataW-1]}}, state_vel}
                           + {{2{ctrl_vel[DataW-1]}}, ctrl_vel});
        end
        ST_P_NB: nb <= add_res;
        ST_P_A1: begin
          acc   <= add_res;
          cov_b <= nb;
        end
        ST_P_A2: acc <= add_res;
        ST_P_A3: cov_a <= add_res;
        ST_P_C:  cov_c <= add_res;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {cov_c, cov_b, cov_a, state_vel, state_pos};
  assign m_axis_tuser  = singular;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready while result held");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_div_idle_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !dstat.busy) else $error("divider busy at output");
  a_sing_skip: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV1 && s == '0 |=> state == ST_P_POS) else $error("update not skipped");

endmodule
